>>> sv/ape_pkg.sv
package ape_pkg;

  localparam int BLOCK_WORDS_DEF = 256;
  localparam logic [19:0] TIMEOUT_RST = 20'd75000;

  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 32;

  // input op codes (in_tuser)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // command kinds
  localparam logic [1:0] CK_READ = 2'd0;
  localparam logic [1:0] CK_WRITE = 2'd1;
  localparam logic [1:0] CK_IDENT = 2'd2;

  // result kinds (out_tuser)
  localparam logic [1:0] RK_REG = 2'd0;
  localparam logic [1:0] RK_HOST = 2'd1;
  localparam logic [1:0] RK_DEV = 2'd2;
  localparam logic [1:0] RK_FIN = 2'd3;

  // task-file register indexes
  localparam logic [2:0] RI_DEVHEAD = 3'd0;
  localparam logic [2:0] RI_FEATURES = 3'd1;
  localparam logic [2:0] RI_COUNT = 3'd2;
  localparam logic [2:0] RI_SECTOR = 3'd3;
  localparam logic [2:0] RI_CYL_LO = 3'd4;
  localparam logic [2:0] RI_CYL_HI = 3'd5;
  localparam logic [2:0] RI_COMMAND = 3'd6;

  // finish codes
  localparam logic [1:0] RC_OK = 2'd0;
  localparam logic [1:0] RC_NOT_READY = 2'd1;
  localparam logic [1:0] RC_TIMEOUT = 2'd2;
  localparam logic [1:0] RC_DEV_ERR = 2'd3;

  // status bits
  localparam int ST_BSY = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;
  localparam int HD_SLAVE = 4;

  localparam logic [7:0] CMD_READ = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_IDENT = 8'hec;
  localparam logic [3:0] DH_LBA = 4'h4;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_READY     = 7'b0000010,
    PH_BUSIDLE   = 7'b0000100,
    PH_DIN_WAIT  = 7'b0001000,
    PH_DIN_XFER  = 7'b0010000,
    PH_DOUT_WAIT = 7'b0100000,
    PH_DOUT_XFER = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    DK_FIN      = 3'd0,
    DK_WORD     = 3'd1,
    DK_WORD_FIN = 3'd2,
    DK_DEVHEAD  = 3'd3,
    DK_ISSUE    = 3'd4
  } dkind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cmd_kind;
    logic [27:0] lba;
    logic [8:0]  sector_count;
    logic [7:0]  status_byte;
    logic [7:0]  head_reg_seen;
    logic [15:0] data_in;
  } item_t;

  // one burst of results from a single request
  typedef struct packed {
    dkind_t      dkind;
    logic        to_dev;
    logic [1:0]  code;
    logic [15:0] data;
    logic [7:0]  dh;
    logic [7:0]  cnt;
    logic [23:0] lba;
    logic [7:0]  cmd;
  } desc_t;

endpackage

>>> sv/ata_pio_command_engine.sv
// Host-side ATA PIO engine for LBA28 READ SECTORS, WRITE SECTORS and IDENTIFY
// DEVICE. Each input request is a start, a device status sample or a data
// word (in_tuser); each result is a task-file write, a word to host or
// device, or a finish with a code (out_tuser), with out_tlast on the final
// result of a request. A request that yields one result or none is taken
// every cycle unless the output stalls; one that yields more holds the input
// until its last result is taken, as the output register shows one result
// per cycle when not stalled: 7 results for the command issue, 2 for the
// final word of a read. A two-entry input skid keeps in_tready registered
// and takes requests while a result waits. Polls that fail beyond
// timeout_polls (cfg_wdata, reset 75000) end the command with a timeout.
module ata_pio_command_engine #(
  parameter int BLOCK_WORDS = ape_pkg::BLOCK_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [19:0]                     cfg_wdata,   // timeout_polls
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd_kind[1:0], lba[29:2], sector_count[38:30], status_byte[46:39],
  // head_reg_seen[54:47], data_in[70:55], zero [71]
  input  logic [ape_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,    // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // reg_index[2:0], reg_value[10:3], data_out[26:11], result_code[28:27],
  // zero [31:29]
  output logic [ape_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,   // kind
  output logic                            out_tlast
);

  ape_pkg::item_t in_item;
  ape_pkg::item_t head_item;
  ape_pkg::desc_t load_desc;
  logic           head_v;
  logic           consume;
  logic           emit_rdy;
  logic           load_v;
  logic [2:0]     res_reg_index;
  logic [7:0]     res_reg_value;
  logic [15:0]    res_data_out;
  logic [1:0]     res_code;

  assign in_item.op            = in_tuser;
  assign in_item.cmd_kind      = in_tdata[1:0];
  assign in_item.lba           = in_tdata[29:2];
  assign in_item.sector_count  = in_tdata[38:30];
  assign in_item.status_byte   = in_tdata[46:39];
  assign in_item.head_reg_seen = in_tdata[54:47];
  assign in_item.data_in       = in_tdata[70:55];

  ape_in_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_item (in_item),
    .push_rdy  (in_tready),
    .head_v    (head_v),
    .head_item (head_item),
    .pop       (consume)
  );

  ape_core #(
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .item_v    (head_v),
    .item      (head_item),
    .emit_rdy  (emit_rdy),
    .consume   (consume),
    .load_v    (load_v),
    .load_desc (load_desc)
  );

  ape_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_v        (load_v),
    .load_desc     (load_desc),
    .emit_rdy      (emit_rdy),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_kind      (out_tuser),
    .res_reg_index (res_reg_index),
    .res_reg_value (res_reg_value),
    .res_data_out  (res_data_out),
    .res_code      (res_code),
    .res_last      (out_tlast)
  );

  assign out_tdata = {3'b000, res_code, res_data_out, res_reg_value, res_reg_index};

endmodule

>>> sv/ape_in_skid.sv
module ape_in_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ape_pkg::item_t    push_item,
  output logic              push_rdy,
  output logic              head_v,
  output ape_pkg::item_t    head_item,
  input  logic              pop
);

  logic           head_v_r, head_v_nxt;
  logic           skid_v_r, skid_v_nxt;
  ape_pkg::item_t head_r, head_nxt;
  ape_pkg::item_t skid_r, skid_nxt;

  assign push_rdy  = !skid_v_r;
  assign head_v    = head_v_r;
  assign head_item = head_r;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop && skid_v_r) begin
      head_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (pop && push) begin
      head_nxt = push_item;
    end else if (pop) begin
      head_v_nxt = 1'b0;
    end else if (push && !head_v_r) begin
      head_nxt   = push_item;
      head_v_nxt = 1'b1;
    end else if (push) begin
      skid_nxt   = push_item;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> sv/ape_core.sv
module ape_core #(
  parameter int BLOCK_WORDS = ape_pkg::BLOCK_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wen,
  input  logic [19:0]       cfg_wdata,
  input  logic              item_v,
  input  ape_pkg::item_t    item,
  input  logic              emit_rdy,
  output logic              consume,
  output logic              load_v,
  output ape_pkg::desc_t    load_desc
);

  localparam int WL_W = $clog2(256 * BLOCK_WORDS + 1);
  localparam int BL_W = $clog2(BLOCK_WORDS + 1);

  ape_pkg::phase_t phase_r, phase_nxt;
  logic [WL_W-1:0] words_left_r, words_left_nxt;
  logic [BL_W-1:0] block_left_r, block_left_nxt;
  logic [19:0]     poll_r, poll_nxt;
  logic [19:0]     timeout_r;
  logic [27:0]     lba_r, lba_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [1:0]      ckind_r, ckind_nxt;

  logic [1:0]      ck;
  logic [8:0]      cnt9;
  logic [BL_W-1:0] next_blk;
  logic [BL_W-1:0] bl_dec;
  logic [WL_W-1:0] wl_dec;
  logic [7:0]      st;
  logic            is_ident;

  assign consume = item_v && emit_rdy;
  assign st = item.status_byte;
  assign ck = (item.cmd_kind == 2'd3) ? ape_pkg::CK_IDENT : item.cmd_kind;
  assign cnt9 = (item.sector_count[7:0] == 8'd0) ? 9'd256 : {1'b0, item.sector_count[7:0]};
  assign next_blk = (words_left_r < WL_W'(BLOCK_WORDS)) ? BL_W'(words_left_r)
                                                        : BL_W'(BLOCK_WORDS);
  assign bl_dec = (block_left_r != '0) ? block_left_r - 1'b1 : '0;
  assign wl_dec = (words_left_r != '0) ? words_left_r - 1'b1 : '0;
  assign is_ident = (ckind_r == ape_pkg::CK_IDENT);

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    block_left_nxt = block_left_r;
    poll_nxt       = poll_r;
    lba_nxt        = lba_r;
    count_nxt      = count_r;
    ckind_nxt      = ckind_r;
    load_v         = 1'b0;
    load_desc      = '0;
    load_desc.dkind = ape_pkg::DK_FIN;

    if (consume) begin
      case (item.op)
        ape_pkg::OP_START: begin
          if (phase_r == ape_pkg::PH_IDLE) begin
            ckind_nxt = ck;
            if (ck == ape_pkg::CK_IDENT) begin
              lba_nxt        = '0;
              count_nxt      = '0;
              words_left_nxt = WL_W'(BLOCK_WORDS);
            end else begin
              lba_nxt        = item.lba;
              count_nxt      = item.sector_count[7:0];
              words_left_nxt = WL_W'(cnt9 * BLOCK_WORDS);
            end
            block_left_nxt = '0;
            poll_nxt       = '0;
            phase_nxt      = ape_pkg::PH_READY;
          end
        end
        ape_pkg::OP_STATUS: begin
          case (phase_r)
            ape_pkg::PH_READY: begin
              if (!st[ape_pkg::ST_DRDY]) begin
                load_v         = 1'b1;
                load_desc.code = ape_pkg::RC_NOT_READY;
              end else begin
                poll_nxt  = '0;
                phase_nxt = ape_pkg::PH_BUSIDLE;
              end
            end
            ape_pkg::PH_BUSIDLE: begin
              if (st[ape_pkg::ST_BSY] || st[ape_pkg::ST_DRQ]) begin
                if (poll_r >= timeout_r) begin
                  load_v         = 1'b1;
                  load_desc.code = ape_pkg::RC_TIMEOUT;
                end else begin
                  poll_nxt = poll_r + 1'b1;
                end
              end else if (item.head_reg_seen[ape_pkg::HD_SLAVE]) begin
                load_v          = 1'b1;
                load_desc.dkind = ape_pkg::DK_DEVHEAD;
                poll_nxt        = '0;
              end else begin
                load_v          = 1'b1;
                load_desc.dkind = ape_pkg::DK_ISSUE;
                load_desc.dh    = is_ident ? 8'h00 : {ape_pkg::DH_LBA, lba_r[27:24]};
                load_desc.cnt   = count_r;
                load_desc.lba   = lba_r[23:0];
                load_desc.cmd   = is_ident ? ape_pkg::CMD_IDENT :
                                  (ckind_r == ape_pkg::CK_WRITE) ? ape_pkg::CMD_WRITE
                                                                 : ape_pkg::CMD_READ;
                poll_nxt        = '0;
                phase_nxt       = (ckind_r == ape_pkg::CK_WRITE) ? ape_pkg::PH_DOUT_WAIT
                                                                 : ape_pkg::PH_DIN_WAIT;
              end
            end
            ape_pkg::PH_DIN_WAIT: begin
              if (st[ape_pkg::ST_BSY]) begin
                if (poll_r >= timeout_r) begin
                  load_v         = 1'b1;
                  load_desc.code = ape_pkg::RC_TIMEOUT;
                end else begin
                  poll_nxt = poll_r + 1'b1;
                end
              end else if (!st[ape_pkg::ST_DRQ]) begin
                load_v         = 1'b1;
                load_desc.code = ape_pkg::RC_DEV_ERR;
              end else begin
                block_left_nxt = next_blk;
                phase_nxt      = ape_pkg::PH_DIN_XFER;
              end
            end
            ape_pkg::PH_DOUT_WAIT: begin
              if (st[ape_pkg::ST_BSY]) begin
                if (poll_r >= timeout_r) begin
                  load_v         = 1'b1;
                  load_desc.code = ape_pkg::RC_TIMEOUT;
                end else begin
                  poll_nxt = poll_r + 1'b1;
                end
              end else if (st[ape_pkg::ST_DRQ]) begin
                if (words_left_r == '0) begin
                  load_v         = 1'b1;
                  load_desc.code = ape_pkg::RC_DEV_ERR;
                end else begin
                  block_left_nxt = next_blk;
                  phase_nxt      = ape_pkg::PH_DOUT_XFER;
                end
              end else begin
                load_v         = 1'b1;
                load_desc.code = st[ape_pkg::ST_ERR] ? ape_pkg::RC_DEV_ERR : ape_pkg::RC_OK;
              end
            end
            default: ;
          endcase
        end
        ape_pkg::OP_DATA: begin
          if (phase_r == ape_pkg::PH_DIN_XFER || phase_r == ape_pkg::PH_DOUT_XFER) begin
            load_v           = 1'b1;
            load_desc.dkind  = ape_pkg::DK_WORD;
            load_desc.to_dev = (phase_r == ape_pkg::PH_DOUT_XFER);
            load_desc.data   = item.data_in;
            block_left_nxt   = bl_dec;
            words_left_nxt   = wl_dec;
            if (bl_dec == '0) begin
              poll_nxt = '0;
              if (phase_r == ape_pkg::PH_DOUT_XFER) begin
                phase_nxt = ape_pkg::PH_DOUT_WAIT;
              end else if (wl_dec == '0) begin
                load_desc.dkind = ape_pkg::DK_WORD_FIN;
                load_desc.code  = ape_pkg::RC_OK;
                phase_nxt       = ape_pkg::PH_IDLE;
              end else begin
                phase_nxt = ape_pkg::PH_DIN_WAIT;
              end
            end
          end
        end
        default: ;
      endcase

      // finish clears the run state
      if (load_v && load_desc.dkind == ape_pkg::DK_FIN) begin
        phase_nxt      = ape_pkg::PH_IDLE;
        words_left_nxt = '0;
        block_left_nxt = '0;
        poll_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ape_pkg::PH_IDLE;
      words_left_r <= '0;
      block_left_r <= '0;
      poll_r       <= '0;
      lba_r        <= '0;
      count_r      <= '0;
      ckind_r      <= '0;
      timeout_r    <= ape_pkg::TIMEOUT_RST;
    end else begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      block_left_r <= block_left_nxt;
      poll_r       <= poll_nxt;
      lba_r        <= lba_nxt;
      count_r      <= count_nxt;
      ckind_r      <= ckind_nxt;
      if (cfg_wen) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

endmodule

>>> sv/ape_emit.sv
module ape_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_v,
  input  ape_pkg::desc_t      load_desc,
  output logic                emit_rdy,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_kind,
  output logic [2:0]          res_reg_index,
  output logic [7:0]          res_reg_value,
  output logic [15:0]         res_data_out,
  output logic [1:0]          res_code,
  output logic                res_last
);

  logic           desc_v_r, desc_v_nxt;
  ape_pkg::desc_t desc_r, desc_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic           take;

  assign res_valid = desc_v_r;
  assign take      = desc_v_r && res_ready;
  assign emit_rdy  = !desc_v_r || (take && res_last);

  always_comb begin
    res_kind      = ape_pkg::RK_REG;
    res_reg_index = '0;
    res_reg_value = '0;
    res_data_out  = '0;
    res_code      = '0;
    res_last      = 1'b1;
    case (desc_r.dkind)
      ape_pkg::DK_FIN: begin
        res_kind = ape_pkg::RK_FIN;
        res_code = desc_r.code;
      end
      ape_pkg::DK_WORD: begin
        res_kind     = desc_r.to_dev ? ape_pkg::RK_DEV : ape_pkg::RK_HOST;
        res_data_out = desc_r.data;
      end
      ape_pkg::DK_WORD_FIN: begin
        if (idx_r == 3'd0) begin
          res_kind     = desc_r.to_dev ? ape_pkg::RK_DEV : ape_pkg::RK_HOST;
          res_data_out = desc_r.data;
          res_last     = 1'b0;
        end else begin
          res_kind = ape_pkg::RK_FIN;
          res_code = desc_r.code;
        end
      end
      ape_pkg::DK_DEVHEAD: begin
        res_reg_index = ape_pkg::RI_DEVHEAD;
      end
      ape_pkg::DK_ISSUE: begin
        res_reg_index = idx_r;
        res_last      = (idx_r == ape_pkg::RI_COMMAND);
        case (idx_r)
          ape_pkg::RI_DEVHEAD:  res_reg_value = desc_r.dh;
          ape_pkg::RI_COUNT:    res_reg_value = desc_r.cnt;
          ape_pkg::RI_SECTOR:   res_reg_value = desc_r.lba[7:0];
          ape_pkg::RI_CYL_LO:   res_reg_value = desc_r.lba[15:8];
          ape_pkg::RI_CYL_HI:   res_reg_value = desc_r.lba[23:16];
          ape_pkg::RI_COMMAND:  res_reg_value = desc_r.cmd;
          default:              res_reg_value = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    desc_v_nxt = desc_v_r;
    desc_nxt   = desc_r;
    idx_nxt    = idx_r;
    if (take && !res_last) begin
      idx_nxt = idx_r + 1'b1;
    end else if (emit_rdy) begin
      desc_v_nxt = load_v;
      idx_nxt    = '0;
      if (load_v) begin
        desc_nxt = load_desc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      desc_v_r <= desc_v_nxt;
      idx_r    <= idx_nxt;
    end
    desc_r <= desc_nxt;
  end

endmodule

>>> sv/ape_checker.sv
module ape_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_wen,
  input logic [19:0]                     cfg_wdata,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ape_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ape_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tlast
);

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ape_pkg::RK_FIN |-> out_tlast)
    else $error("finish not marked last");

  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ape_pkg::RK_REG && out_tdata[2:0] == ape_pkg::RI_COMMAND
    |-> out_tlast)
    else $error("command write not marked last");

  a_issue_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == ape_pkg::RK_REG &&
    out_tdata[2:0] == ape_pkg::RI_CYL_HI
    |=> out_tvalid && out_tuser == ape_pkg::RK_REG && out_tdata[2:0] == ape_pkg::RI_COMMAND)
    else $error("command write does not follow cylinder high");

endmodule

bind ata_pio_command_engine ape_checker u_ape_checker (.*);

>>> tb/ata_pio_command_engine_tb.sv
import ape_pkg::*;

typedef struct packed {
  logic [1:0]  kind;
  logic [2:0]  reg_index;
  logic [7:0]  reg_value;
  logic [15:0] data_out;
  logic [1:0]  result_code;
  logic        last;
} ata_result_t;

class engine_scoreboard;
  bit [19:0]   timeout_polls;
  phase_t      phase;
  bit [16:0]   words_left;
  bit [8:0]    block_left;
  bit [19:0]   poll_count;
  bit [27:0]   lba;
  bit [7:0]    count;
  bit [1:0]    cmd;
  ata_result_t pending_results[$];
  int          mismatches;
  int          results_seen;
  int          finishes[4];

  function new();
    timeout_polls = TIMEOUT_RST;
    phase = PH_IDLE;
    words_left = '0;
    block_left = '0;
    poll_count = '0;
    lba = '0;
    count = '0;
    cmd = CK_READ;
    mismatches = 0;
    results_seen = 0;
    foreach (finishes[i]) finishes[i] = 0;
  endfunction

  function void emit(bit [1:0] kind, bit [2:0] idx, bit [7:0] val, bit [15:0] data,
                     bit [1:0] code);
    pending_results.push_back(ata_result_t'{kind, idx, val, data, code, 1'b0});
  endfunction

  function void finish_cmd(bit [1:0] code);
    emit(RK_FIN, '0, '0, '0, code);
    finishes[code]++;
    phase = PH_IDLE;
    words_left = '0;
    block_left = '0;
    poll_count = '0;
  endfunction

  function void failed_poll();
    if (poll_count >= timeout_polls) finish_cmd(RC_TIMEOUT);
    else poll_count++;
  endfunction

  function bit [8:0] next_block();
    return words_left < BLOCK_WORDS_DEF ? words_left[8:0] : 9'(BLOCK_WORDS_DEF);
  endfunction

  function void apply_request(item_t it);
    int          first;
    bit [7:0]    dh;
    bit [7:0]    cmd_byte;
    bit          din;
    ata_result_t tail;
    first = pending_results.size();
    case (it.op)
      OP_START: if (phase == PH_IDLE) begin
        cmd = it.cmd_kind == 2'd3 ? CK_IDENT : it.cmd_kind;
        if (cmd == CK_IDENT) begin
          lba = '0;
          count = '0;
          words_left = 17'(BLOCK_WORDS_DEF);
        end else begin
          lba = it.lba;
          count = it.sector_count[7:0];
          words_left = 17'((count == 0 ? 256 : int'(count)) * BLOCK_WORDS_DEF);
        end
        block_left = '0;
        poll_count = '0;
        phase = PH_READY;
      end
      OP_STATUS: case (phase)
        PH_READY: begin
          if (!it.status_byte[ST_DRDY]) finish_cmd(RC_NOT_READY);
          else begin
            poll_count = '0;
            phase = PH_BUSIDLE;
          end
        end
        PH_BUSIDLE: begin
          if (it.status_byte[ST_BSY] || it.status_byte[ST_DRQ]) failed_poll();
          else if (it.head_reg_seen[HD_SLAVE]) begin
            // slave selected: reselect master and poll again
            emit(RK_REG, RI_DEVHEAD, 8'h00, '0, RC_OK);
            poll_count = '0;
          end else begin
            if (cmd == CK_IDENT) begin
              dh = 8'h00;
              cmd_byte = CMD_IDENT;
            end else begin
              dh = {DH_LBA, lba[27:24]};
              cmd_byte = cmd == CK_WRITE ? CMD_WRITE : CMD_READ;
            end
            emit(RK_REG, RI_DEVHEAD, dh, '0, RC_OK);
            emit(RK_REG, RI_FEATURES, 8'h00, '0, RC_OK);
            emit(RK_REG, RI_COUNT, count, '0, RC_OK);
            emit(RK_REG, RI_SECTOR, lba[7:0], '0, RC_OK);
            emit(RK_REG, RI_CYL_LO, lba[15:8], '0, RC_OK);
            emit(RK_REG, RI_CYL_HI, lba[23:16], '0, RC_OK);
            emit(RK_REG, RI_COMMAND, cmd_byte, '0, RC_OK);
            poll_count = '0;
            phase = cmd == CK_WRITE ? PH_DOUT_WAIT : PH_DIN_WAIT;
          end
        end
        PH_DIN_WAIT: begin
          if (it.status_byte[ST_BSY]) failed_poll();
          else if (!it.status_byte[ST_DRQ]) finish_cmd(RC_DEV_ERR);
          else begin
            block_left = next_block();
            phase = PH_DIN_XFER;
          end
        end
        PH_DOUT_WAIT: begin
          if (it.status_byte[ST_BSY]) failed_poll();
          else if (it.status_byte[ST_DRQ]) begin
            if (words_left == 0) finish_cmd(RC_DEV_ERR);
            else begin
              block_left = next_block();
              phase = PH_DOUT_XFER;
            end
          end else finish_cmd(it.status_byte[ST_ERR] ? RC_DEV_ERR : RC_OK);
        end
        default: ;
      endcase
      OP_DATA: if (phase == PH_DIN_XFER || phase == PH_DOUT_XFER) begin
        din = phase == PH_DIN_XFER;
        emit(din ? RK_HOST : RK_DEV, '0, '0, it.data_in, RC_OK);
        if (block_left > 0) block_left--;
        if (words_left > 0) words_left--;
        if (block_left == 0) begin
          poll_count = '0;
          if (!din) phase = PH_DOUT_WAIT;
          else if (words_left == 0) finish_cmd(RC_OK);
          else phase = PH_DIN_WAIT;
        end
      end
      default: ;
    endcase
    if (pending_results.size() > first) begin
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  function void compare(string field, int unsigned want, int unsigned got, time stamp);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", stamp, field, want, got);
      mismatches++;
    end
  endfunction

  function void match_result(ata_result_t got, time stamp);
    ata_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d data %0d",
               stamp, got.kind, got.data_out);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare("kind", want.kind, got.kind, stamp);
    compare("reg_index", want.reg_index, got.reg_index, stamp);
    compare("reg_value", want.reg_value, got.reg_value, stamp);
    compare("data_out", want.data_out, got.data_out, stamp);
    compare("result_code", want.result_code, got.result_code, stamp);
    compare("last", want.last, got.last, stamp);
  endfunction
endclass

module ata_pio_command_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] CK_ALIAS = 2'd3;
  localparam int MODE_RANDOM = 0;
  localparam int MODE_CLEAN = 1;
  localparam int MODE_TO_BUS = 2;
  localparam int MODE_TO_DATA = 3;
  localparam int DRAIN = 32;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [19:0]           cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  engine_scoreboard sb;
  bit quiet = 1'b0;
  bit xfer_ok = 1'b0;
  int total_requests = 0;
  int ctrl_requests = 0;
  int commands = 0;
  int stall_cycles = 0;

  ata_pio_command_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.match_result(ata_result_t'{out_tuser, out_tdata[2:0], out_tdata[10:3],
                                    out_tdata[26:11], out_tdata[28:27], out_tlast}, $time);
    out_tready <= quiet || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[ata_pio_command_engine] ERROR");
      $finish;
    end
  end

  function automatic item_t random_item(logic [1:0] op);
    item_t it;
    it.op = op;
    it.cmd_kind = 2'($urandom);
    it.lba = 28'($urandom);
    it.sector_count = 9'($urandom);
    it.status_byte = 8'($urandom);
    it.head_reg_seen = 8'($urandom);
    it.data_in = 16'($urandom);
    return it;
  endfunction

  task automatic put_request(item_t it);
    while (!quiet && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {1'b0, it.data_in, it.head_reg_seen, it.status_byte, it.sector_count,
                 it.lba, it.cmd_kind};
    in_tuser <= it.op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_request(it);
    total_requests++;
    if (it.op != OP_DATA) ctrl_requests++;
  endtask

  task automatic poll(logic [7:0] st, logic slave);
    item_t it;
    it = random_item(OP_STATUS);
    it.status_byte = st;
    it.head_reg_seen[HD_SLAVE] = slave;
    put_request(it);
  endtask

  task automatic start_cmd(logic [1:0] ck, logic [27:0] lba, logic [8:0] cnt);
    item_t it;
    it = random_item(OP_START);
    it.cmd_kind = ck;
    it.lba = lba;
    it.sector_count = cnt;
    put_request(it);
    commands++;
  endtask

  // drives one command from start to its finish, following the predicted phase;
  // data blocks are only granted while xfer_ok is set
  task automatic run_command(logic [1:0] ck, logic [8:0] cnt, int mode);
    item_t it;
    logic [7:0] st;
    int roll;
    start_cmd(ck, 28'($urandom), cnt);
    while (sb.phase != PH_IDLE) begin
      roll = $urandom_range(0, 99);
      st = 8'($urandom);
      if (mode == MODE_RANDOM && roll < 5) begin
        case ($urandom_range(0, 2))
          0: it = random_item(OP_START);
          1: it = random_item(OP_NONE);
          default: it = random_item((sb.phase == PH_DIN_XFER || sb.phase == PH_DOUT_XFER) ?
                                    OP_STATUS : OP_DATA);
        endcase
        put_request(it);
      end else begin
        roll = $urandom_range(0, 99);
        case (sb.phase)
          PH_READY: begin
            st[ST_DRDY] = mode != MODE_RANDOM || roll < 88;
            poll(st, 1'($urandom));
          end
          PH_BUSIDLE: begin
            if (mode == MODE_TO_BUS || (mode == MODE_RANDOM && roll < 30)) begin
              if (!st[ST_BSY] && !st[ST_DRQ]) begin
                if (roll % 2 == 0) st[ST_BSY] = 1'b1;
                else st[ST_DRQ] = 1'b1;
              end
              poll(st, 1'($urandom));
            end else begin
              st[ST_BSY] = 1'b0;
              st[ST_DRQ] = 1'b0;
              poll(st, mode == MODE_RANDOM && roll < 42);
            end
          end
          PH_DIN_WAIT, PH_DOUT_WAIT: begin
            st[ST_BSY] = mode == MODE_TO_DATA || (mode == MODE_RANDOM && roll < 25);
            if (!st[ST_BSY]) begin
              if (mode == MODE_RANDOM) begin
                st[ST_DRQ] = sb.phase == PH_DIN_WAIT ? roll >= 40 : roll < 65;
              end else begin
                st[ST_DRQ] = sb.phase == PH_DIN_WAIT || sb.words_left != 0;
                st[ST_ERR] = 1'b0;
              end
              if (!xfer_ok) st[ST_DRQ] = 1'b0;
            end
            poll(st, 1'($urandom));
          end
          default: put_request(random_item(OP_DATA));
        endcase
      end
    end
  endtask

  task automatic random_chunk(int n);
    int stop;
    int mode;
    logic [8:0] cnt;
    stop = ctrl_requests + n;
    while (ctrl_requests < stop) begin
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0: put_request(random_item(OP_STATUS));
          1: put_request(random_item(OP_DATA));
          default: put_request(random_item(OP_NONE));
        endcase
      end else begin
        cnt = $urandom_range(0, 99) < 70 ? 9'($urandom_range(1, 2)) : 9'($urandom);
        mode = MODE_RANDOM;
        if (sb.timeout_polls <= 16 && $urandom_range(0, 99) < 25)
          mode = $urandom_range(0, 1) ? MODE_TO_BUS : MODE_TO_DATA;
        run_command(2'($urandom), cnt, mode);
      end
    end
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_timeout(logic [19:0] v);
    quiesce();
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.timeout_polls = v;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ignored while idle
    put_request(random_item(OP_STATUS));
    put_request(random_item(OP_DATA));
    put_request(random_item(OP_NONE));
    // not ready, count above 256
    start_cmd(CK_READ, 28'hfffffff, 9'h1ff);
    poll(8'hbf, 1'b1);
    // count 256, busy poll, slave reselect, write ends on ERR
    start_cmd(CK_WRITE, 28'h0, 9'h100);
    poll(8'h40, 1'b0);
    poll(8'h48, 1'b0);
    poll(8'h40, 1'b1);
    poll(8'h40, 1'b0);
    poll(8'h41, 1'b0);
    // write ends ok when DRQ drops; start while busy is ignored
    start_cmd(CK_WRITE, 28'hfffffff, 9'h001);
    poll(8'hff, 1'b0);
    poll(8'h00, 1'b0);
    poll(8'h80, 1'b0);
    put_request(random_item(OP_START));
    poll(8'h40, 1'b0);
    // kind 3 runs as identify; no DRQ on data-in
    start_cmd(CK_ALIAS, 28'($urandom), 9'($urandom));
    poll(8'h40, 1'b0);
    poll(8'h40, 1'b0);
    poll(8'h76, 1'b0);
    random_chunk(12);

    write_timeout(20'd1);
    random_chunk(12);

    // one full identify block with no idling on either side
    write_timeout(20'd1000000);
    quiet = 1'b1;
    xfer_ok = 1'b1;
    run_command(CK_IDENT, 9'd0, MODE_CLEAN);
    xfer_ok = 1'b0;
    quiet = 1'b0;

    write_timeout(20'($urandom_range(2, 12)));
    random_chunk(14);

    quiesce();
    $display("run: %0d requests, %0d commands, %0d results checked",
             total_requests, commands, sb.results_seen);
    $display("finishes: ok %0d, not ready %0d, timeout %0d, device error %0d",
             sb.finishes[RC_OK], sb.finishes[RC_NOT_READY], sb.finishes[RC_TIMEOUT],
             sb.finishes[RC_DEV_ERR]);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[ata_pio_command_engine] OK");
    end else begin
      $display("[ata_pio_command_engine] ERROR");
    end
    $finish;
  end
endmodule
